/* sv/bvc_pkg.sv */
// ---------------------------------------------------------------------------
// bvc_pkg: battery voltage classifier shared definitions
// constants, register indexes, status codes and datapath widths
// ---------------------------------------------------------------------------
package bvc_pkg;

  // channel count and samples per average
  localparam int CHANNELS = 4;
  localparam int SAMPLES  = 16;

  // field widths
  localparam int CH_W     = 2;
  localparam int ADC_W    = 12;
  localparam int REG_W    = 16;
  localparam int SUM_W    = 18;
  localparam int CNT_W    = 7;
  localparam int PCT_W    = 10;
  localparam int STAT_W   = 3;
  localparam int IDX_W    = 3;

  // serial divider: dividend, divisor and step counter widths
  localparam int DIV_W    = 27;
  localparam int DEN_W    = 17;
  localparam int DCNT_W   = 5;
  localparam int DIV_STEPS = DIV_W;

  // serial multiplier: one bit of the pin voltage per cycle
  localparam int PROD_W   = ADC_W + REG_W;
  localparam int MCNT_W   = 4;
  localparam int MUL_STEPS = ADC_W;

  // calibrated numerator width (signed)
  localparam int NUM_W    = PROD_W + 2;

  // percent scale in tenths
  localparam int PCT_FULL = 1000;

  // register indexes
  localparam logic [IDX_W-1:0] REG_CAL_SLOPE     = 3'd0;
  localparam logic [IDX_W-1:0] REG_CAL_OFFSET    = 3'd1;
  localparam logic [IDX_W-1:0] REG_EMPTY_MV      = 3'd2;
  localparam logic [IDX_W-1:0] REG_FULL_MV       = 3'd3;
  localparam logic [IDX_W-1:0] REG_LOW_MV        = 3'd4;
  localparam logic [IDX_W-1:0] REG_OVER_MV       = 3'd5;
  localparam logic [IDX_W-1:0] REG_DISCONNECT_MV = 3'd6;

  // register reset values
  localparam logic [REG_W-1:0] RST_CAL_SLOPE     = 16'd1024;
  localparam logic [REG_W-1:0] RST_CAL_OFFSET    = 16'd0;
  localparam logic [REG_W-1:0] RST_EMPTY_MV      = 16'd10500;
  localparam logic [REG_W-1:0] RST_FULL_MV       = 16'd12700;
  localparam logic [REG_W-1:0] RST_LOW_MV        = 16'd11800;
  localparam logic [REG_W-1:0] RST_OVER_MV       = 16'd14600;
  localparam logic [REG_W-1:0] RST_DISCONNECT_MV = 16'd1000;

  // status codes
  localparam logic [STAT_W-1:0] ST_NOT_CONNECTED = 3'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY         = 3'd1;
  localparam logic [STAT_W-1:0] ST_LOW           = 3'd2;
  localparam logic [STAT_W-1:0] ST_OVER_VOLTAGE  = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL          = 3'd4;
  localparam logic [STAT_W-1:0] ST_NORMAL        = 3'd5;

  // operation codes
  localparam logic OP_ACCUMULATE = 1'b0;
  localparam logic OP_AVERAGED   = 1'b1;

  // sequencer states, one-hot
  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_DIV_RAW = 8'b0000_0010,
    S_DIV_MV  = 8'b0000_0100,
    S_MUL     = 8'b0000_1000,
    S_CAL     = 8'b0001_0000,
    S_PREP    = 8'b0010_0000,
    S_DIV_PCT = 8'b0100_0000,
    S_EMIT    = 8'b1000_0000
  } state_t;

endpackage

/* sv/battery_voltage_classifier.sv */
// ---------------------------------------------------------------------------
// battery_voltage_classifier
// averages adc samples per channel, calibrates to battery millivolts and
// reports state of charge in tenths of a percent plus a status code
// ---------------------------------------------------------------------------
//
//  channel | ports                                        | direction
//  --------+----------------------------------------------+----------
//  input   | in_valid, in_stall, in_op, in_channel,       | in
//          | in_sample_raw, in_sample_mv                  |
//  result  | out_valid, out_stall, out_channel,           | out
//          | out_avg_raw, out_avg_adc_mv, out_battery_mv, |
//          | out_percent_tenths, out_status               |
//  config  | cfg_we, cfg_index, cfg_wdata                 | in
//
// one transaction at a time; in_stall is low only while the sequencer idles
// an op 0 transaction that does not close an average only updates the channel sums
// a closing op 0 transaction runs the 27-step shared serial divider on both sums,
//   then the 12-step shift-add multiplier for the calibration gain, then the
//   divider once more for the percent; an op 1 starts at the multiplier; when
//   the percent needs no division (battery at or past the empty or full mark,
//   or an empty range) that last division is skipped
// a finished result waits in the output register; a new transaction is taken
//   while it waits, only the final load waits for the register to free up,
//   which holds the sequencer in S_EMIT while the receiver keeps stalling
// rst_n is synchronous: registers take their reset values, sums clear
// ---------------------------------------------------------------------------
module battery_voltage_classifier (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_op,
  input  logic [bvc_pkg::CH_W-1:0]         in_channel,
  input  logic [bvc_pkg::ADC_W-1:0]        in_sample_raw,
  input  logic [bvc_pkg::ADC_W-1:0]        in_sample_mv,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [bvc_pkg::CH_W-1:0]         out_channel,
  output logic [bvc_pkg::ADC_W-1:0]        out_avg_raw,
  output logic [bvc_pkg::ADC_W-1:0]        out_avg_adc_mv,
  output logic [bvc_pkg::REG_W-1:0]        out_battery_mv,
  output logic [bvc_pkg::PCT_W-1:0]        out_percent_tenths,
  output logic [bvc_pkg::STAT_W-1:0]       out_status,
  // configuration write port
  input  logic                             cfg_we,
  input  logic [bvc_pkg::IDX_W-1:0]        cfg_index,
  input  logic [bvc_pkg::REG_W-1:0]        cfg_wdata
);

  // ---------------- state ----------------
  bvc_pkg::state_t state_r, state_nxt;

  // configuration registers
  logic [bvc_pkg::REG_W-1:0] slope_r, slope_nxt;
  logic [bvc_pkg::REG_W-1:0] offset_r, offset_nxt;
  logic [bvc_pkg::REG_W-1:0] empty_r, empty_nxt;
  logic [bvc_pkg::REG_W-1:0] full_r, full_nxt;
  logic [bvc_pkg::REG_W-1:0] low_r, low_nxt;
  logic [bvc_pkg::REG_W-1:0] over_r, over_nxt;
  logic [bvc_pkg::REG_W-1:0] disc_r, disc_nxt;

  // per-channel accumulators
  logic [bvc_pkg::SUM_W-1:0] raw_sum_r [bvc_pkg::CHANNELS];
  logic [bvc_pkg::SUM_W-1:0] raw_sum_nxt [bvc_pkg::CHANNELS];
  logic [bvc_pkg::SUM_W-1:0] mv_sum_r [bvc_pkg::CHANNELS];
  logic [bvc_pkg::SUM_W-1:0] mv_sum_nxt [bvc_pkg::CHANNELS];
  logic [bvc_pkg::CNT_W-1:0] count_r [bvc_pkg::CHANNELS];
  logic [bvc_pkg::CNT_W-1:0] count_nxt [bvc_pkg::CHANNELS];

  // serial divider
  logic [bvc_pkg::DIV_W-1:0]  div_num_r, div_num_nxt;
  logic [bvc_pkg::DEN_W-1:0]  div_den_r, div_den_nxt;
  logic [bvc_pkg::DEN_W-1:0]  div_rem_r, div_rem_nxt;
  logic [bvc_pkg::DIV_W-1:0]  div_quo_r, div_quo_nxt;
  logic [bvc_pkg::DCNT_W-1:0] div_cnt_r, div_cnt_nxt;

  // serial multiplier
  logic [bvc_pkg::ADC_W-1:0]  mul_sh_r, mul_sh_nxt;
  logic [bvc_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic [bvc_pkg::MCNT_W-1:0] mul_cnt_r, mul_cnt_nxt;

  // working payload
  logic [bvc_pkg::CH_W-1:0]   ch_r, ch_nxt;
  logic [bvc_pkg::SUM_W-1:0]  mv_hold_r, mv_hold_nxt;
  logic [bvc_pkg::ADC_W-1:0]  avg_raw_r, avg_raw_nxt;
  logic [bvc_pkg::ADC_W-1:0]  avg_mv_r, avg_mv_nxt;
  logic [bvc_pkg::REG_W-1:0]  bat_r, bat_nxt;
  logic [bvc_pkg::PCT_W-1:0]  pct_r, pct_nxt;
  logic [bvc_pkg::STAT_W-1:0] stat_r, stat_nxt;

  // output register
  logic                       out_valid_r, out_valid_nxt;
  logic [bvc_pkg::CH_W-1:0]   o_ch_r, o_ch_nxt;
  logic [bvc_pkg::ADC_W-1:0]  o_raw_r, o_raw_nxt;
  logic [bvc_pkg::ADC_W-1:0]  o_mv_r, o_mv_nxt;
  logic [bvc_pkg::REG_W-1:0]  o_bat_r, o_bat_nxt;
  logic [bvc_pkg::PCT_W-1:0]  o_pct_r, o_pct_nxt;
  logic [bvc_pkg::STAT_W-1:0] o_stat_r, o_stat_nxt;

  // ---------------- datapath helpers ----------------
  logic                        in_fire;
  logic                        ch_ok;
  logic [bvc_pkg::SUM_W-1:0]   raw_acc, mv_acc;
  logic [bvc_pkg::CNT_W-1:0]   cnt_acc;

  // divider step: shift in one dividend bit, trial subtract
  logic [bvc_pkg::DEN_W:0]     rem_sh;
  logic                        div_ge;
  logic [bvc_pkg::DEN_W-1:0]   rem_step;
  logic [bvc_pkg::DIV_W-1:0]   quo_step;
  logic                        div_last;

  // calibration
  logic signed [bvc_pkg::NUM_W-1:0] cal_num;
  logic signed [bvc_pkg::NUM_W-1:0] off_ext;
  logic [bvc_pkg::NUM_W-1:0]        cal_rnd;
  logic [bvc_pkg::NUM_W-11:0]       cal_q;
  logic [bvc_pkg::REG_W-1:0]        cal_bat;

  // percent setup
  logic [bvc_pkg::REG_W-1:0]   pct_range;
  logic [bvc_pkg::REG_W-1:0]   pct_diff;
  logic [bvc_pkg::DIV_W-1:0]   pct_num;
  logic [bvc_pkg::STAT_W-1:0]  prep_stat;
  logic                        out_free;

  assign in_stall = (state_r != bvc_pkg::S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign ch_ok    = (32'(in_channel) < bvc_pkg::CHANNELS);
  assign out_free = !out_valid_r || !out_stall;

  // accumulate path for the addressed channel
  assign raw_acc = raw_sum_r[in_channel] + bvc_pkg::SUM_W'(in_sample_raw);
  assign mv_acc  = mv_sum_r[in_channel] + bvc_pkg::SUM_W'(in_sample_mv);
  assign cnt_acc = count_r[in_channel] + 1'b1;

  // restoring division, one quotient bit per cycle
  assign rem_sh   = {div_rem_r, div_num_r[bvc_pkg::DIV_W-1]};
  assign div_ge   = (rem_sh >= {1'b0, div_den_r});
  assign rem_step = div_ge ? bvc_pkg::DEN_W'(rem_sh - {1'b0, div_den_r})
                           : rem_sh[bvc_pkg::DEN_W-1:0];
  assign quo_step = {div_quo_r[bvc_pkg::DIV_W-2:0], div_ge};
  assign div_last = (div_cnt_r == bvc_pkg::DCNT_W'(bvc_pkg::DIV_STEPS - 1));

  // gain product plus offset scaled by 1024, rounded half up
  assign off_ext = {{(bvc_pkg::NUM_W - bvc_pkg::REG_W - 10){offset_r[bvc_pkg::REG_W-1]}},
                    offset_r, 10'b0};
  assign cal_num = $signed({2'b00, prod_r}) + off_ext;
  assign cal_rnd = bvc_pkg::NUM_W'(cal_num) + bvc_pkg::NUM_W'(512);
  assign cal_q   = cal_rnd[bvc_pkg::NUM_W-1:10];

  always_comb begin
    if (cal_num[bvc_pkg::NUM_W-1] || (cal_num == '0)) begin
      cal_bat = '0;
    end else if (|cal_q[bvc_pkg::NUM_W-11:bvc_pkg::REG_W]) begin
      cal_bat = '1;
    end else begin
      cal_bat = cal_q[bvc_pkg::REG_W-1:0];
    end
  end

  // percent numerator 2000*(v-empty)+range, divisor 2*range
  assign pct_range = full_r - empty_r;
  assign pct_diff  = bat_r - empty_r;
  assign pct_num   = bvc_pkg::DIV_W'(pct_diff) * bvc_pkg::DIV_W'(2 * bvc_pkg::PCT_FULL)
                   + bvc_pkg::DIV_W'(pct_range);

  // ordered threshold tests
  always_comb begin
    if (bat_r < disc_r) begin
      prep_stat = bvc_pkg::ST_NOT_CONNECTED;
    end else if (bat_r <= empty_r) begin
      prep_stat = bvc_pkg::ST_EMPTY;
    end else if (bat_r < low_r) begin
      prep_stat = bvc_pkg::ST_LOW;
    end else if (bat_r > over_r) begin
      prep_stat = bvc_pkg::ST_OVER_VOLTAGE;
    end else if (bat_r >= full_r) begin
      prep_stat = bvc_pkg::ST_FULL;
    end else begin
      prep_stat = bvc_pkg::ST_NORMAL;
    end
  end

  // ---------------- configuration writes ----------------
  always_comb begin
    slope_nxt  = slope_r;
    offset_nxt = offset_r;
    empty_nxt  = empty_r;
    full_nxt   = full_r;
    low_nxt    = low_r;
    over_nxt   = over_r;
    disc_nxt   = disc_r;
    if (cfg_we) begin
      case (cfg_index)
        bvc_pkg::REG_CAL_SLOPE:     slope_nxt  = cfg_wdata;
        bvc_pkg::REG_CAL_OFFSET:    offset_nxt = cfg_wdata;
        bvc_pkg::REG_EMPTY_MV:      empty_nxt  = cfg_wdata;
        bvc_pkg::REG_FULL_MV:       full_nxt   = cfg_wdata;
        bvc_pkg::REG_LOW_MV:        low_nxt    = cfg_wdata;
        bvc_pkg::REG_OVER_MV:       over_nxt   = cfg_wdata;
        bvc_pkg::REG_DISCONNECT_MV: disc_nxt   = cfg_wdata;
        default: ;  // unknown index: write dropped
      endcase
    end
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt   = state_r;
    raw_sum_nxt = raw_sum_r;
    mv_sum_nxt  = mv_sum_r;
    count_nxt   = count_r;
    div_num_nxt = div_num_r;
    div_den_nxt = div_den_r;
    div_rem_nxt = div_rem_r;
    div_quo_nxt = div_quo_r;
    div_cnt_nxt = div_cnt_r;
    mul_sh_nxt  = mul_sh_r;
    prod_nxt    = prod_r;
    mul_cnt_nxt = mul_cnt_r;
    ch_nxt      = ch_r;
    mv_hold_nxt = mv_hold_r;
    avg_raw_nxt = avg_raw_r;
    avg_mv_nxt  = avg_mv_r;
    bat_nxt     = bat_r;
    pct_nxt     = pct_r;
    stat_nxt    = stat_r;
    out_valid_nxt = out_valid_r && out_stall;
    o_ch_nxt    = o_ch_r;
    o_raw_nxt   = o_raw_r;
    o_mv_nxt    = o_mv_r;
    o_bat_nxt   = o_bat_r;
    o_pct_nxt   = o_pct_r;
    o_stat_nxt  = o_stat_r;

    // divider advances one step in any of its states
    if ((state_r == bvc_pkg::S_DIV_RAW) || (state_r == bvc_pkg::S_DIV_MV) ||
        (state_r == bvc_pkg::S_DIV_PCT)) begin
      div_num_nxt = {div_num_r[bvc_pkg::DIV_W-2:0], 1'b0};
      div_rem_nxt = rem_step;
      div_quo_nxt = quo_step;
      div_cnt_nxt = div_cnt_r + 1'b1;
    end

    case (state_r)
      bvc_pkg::S_IDLE: begin
        if (in_fire && ch_ok) begin
          ch_nxt = in_channel;
          if (in_op == bvc_pkg::OP_AVERAGED) begin
            avg_raw_nxt = in_sample_raw;
            avg_mv_nxt  = in_sample_mv;
            mul_sh_nxt  = in_sample_mv;
            prod_nxt    = '0;
            mul_cnt_nxt = '0;
            state_nxt   = bvc_pkg::S_MUL;
          end else if (cnt_acc == bvc_pkg::CNT_W'(bvc_pkg::SAMPLES)) begin
            // average closes: clear the channel, divide both sums
            raw_sum_nxt[in_channel] = '0;
            mv_sum_nxt[in_channel]  = '0;
            count_nxt[in_channel]   = '0;
            mv_hold_nxt = mv_acc;
            div_num_nxt = bvc_pkg::DIV_W'(raw_acc);
            div_den_nxt = bvc_pkg::DEN_W'(bvc_pkg::SAMPLES);
            div_rem_nxt = '0;
            div_quo_nxt = '0;
            div_cnt_nxt = '0;
            state_nxt   = bvc_pkg::S_DIV_RAW;
          end else begin
            raw_sum_nxt[in_channel] = raw_acc;
            mv_sum_nxt[in_channel]  = mv_acc;
            count_nxt[in_channel]   = cnt_acc;
          end
        end
      end

      bvc_pkg::S_DIV_RAW: begin
        if (div_last) begin
          avg_raw_nxt = quo_step[bvc_pkg::ADC_W-1:0];
          div_num_nxt = bvc_pkg::DIV_W'(mv_hold_r);
          div_rem_nxt = '0;
          div_quo_nxt = '0;
          div_cnt_nxt = '0;
          state_nxt   = bvc_pkg::S_DIV_MV;
        end
      end

      bvc_pkg::S_DIV_MV: begin
        if (div_last) begin
          avg_mv_nxt  = quo_step[bvc_pkg::ADC_W-1:0];
          mul_sh_nxt  = quo_step[bvc_pkg::ADC_W-1:0];
          prod_nxt    = '0;
          mul_cnt_nxt = '0;
          state_nxt   = bvc_pkg::S_MUL;
        end
      end

      bvc_pkg::S_MUL: begin
        // msb first shift-add
        prod_nxt = {prod_r[bvc_pkg::PROD_W-2:0], 1'b0}
                 + (mul_sh_r[bvc_pkg::ADC_W-1] ? bvc_pkg::PROD_W'(slope_r)
                                               : bvc_pkg::PROD_W'(0));
        mul_sh_nxt  = {mul_sh_r[bvc_pkg::ADC_W-2:0], 1'b0};
        mul_cnt_nxt = mul_cnt_r + 1'b1;
        if (mul_cnt_r == bvc_pkg::MCNT_W'(bvc_pkg::MUL_STEPS - 1)) begin
          state_nxt = bvc_pkg::S_CAL;
        end
      end

      bvc_pkg::S_CAL: begin
        bat_nxt   = cal_bat;
        state_nxt = bvc_pkg::S_PREP;
      end

      bvc_pkg::S_PREP: begin
        stat_nxt = prep_stat;
        if ((full_r <= empty_r) || (bat_r <= empty_r)) begin
          pct_nxt   = '0;
          state_nxt = bvc_pkg::S_EMIT;
        end else if (bat_r >= full_r) begin
          pct_nxt   = bvc_pkg::PCT_W'(bvc_pkg::PCT_FULL);
          state_nxt = bvc_pkg::S_EMIT;
        end else begin
          div_num_nxt = pct_num;
          div_den_nxt = {pct_range, 1'b0};
          div_rem_nxt = '0;
          div_quo_nxt = '0;
          div_cnt_nxt = '0;
          state_nxt   = bvc_pkg::S_DIV_PCT;
        end
      end

      bvc_pkg::S_DIV_PCT: begin
        if (div_last) begin
          pct_nxt   = quo_step[bvc_pkg::PCT_W-1:0];
          state_nxt = bvc_pkg::S_EMIT;
        end
      end

      bvc_pkg::S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_ch_nxt   = ch_r;
          o_raw_nxt  = avg_raw_r;
          o_mv_nxt   = avg_mv_r;
          o_bat_nxt  = bat_r;
          o_pct_nxt  = pct_r;
          o_stat_nxt = stat_r;
          state_nxt  = bvc_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = bvc_pkg::S_IDLE;
      end
    endcase
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bvc_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      slope_r     <= bvc_pkg::RST_CAL_SLOPE;
      offset_r    <= bvc_pkg::RST_CAL_OFFSET;
      empty_r     <= bvc_pkg::RST_EMPTY_MV;
      full_r      <= bvc_pkg::RST_FULL_MV;
      low_r       <= bvc_pkg::RST_LOW_MV;
      over_r      <= bvc_pkg::RST_OVER_MV;
      disc_r      <= bvc_pkg::RST_DISCONNECT_MV;
      div_cnt_r   <= '0;
      mul_cnt_r   <= '0;
      for (int i = 0; i < bvc_pkg::CHANNELS; i++) begin
        raw_sum_r[i] <= '0;
        mv_sum_r[i]  <= '0;
        count_r[i]   <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      slope_r     <= slope_nxt;
      offset_r    <= offset_nxt;
      empty_r     <= empty_nxt;
      full_r      <= full_nxt;
      low_r       <= low_nxt;
      over_r      <= over_nxt;
      disc_r      <= disc_nxt;
      div_cnt_r   <= div_cnt_nxt;
      mul_cnt_r   <= mul_cnt_nxt;
      raw_sum_r   <= raw_sum_nxt;
      mv_sum_r    <= mv_sum_nxt;
      count_r     <= count_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    div_num_r <= div_num_nxt;
    div_den_r <= div_den_nxt;
    div_rem_r <= div_rem_nxt;
    div_quo_r <= div_quo_nxt;
    mul_sh_r  <= mul_sh_nxt;
    prod_r    <= prod_nxt;
    ch_r      <= ch_nxt;
    mv_hold_r <= mv_hold_nxt;
    avg_raw_r <= avg_raw_nxt;
    avg_mv_r  <= avg_mv_nxt;
    bat_r     <= bat_nxt;
    pct_r     <= pct_nxt;
    stat_r    <= stat_nxt;
    o_ch_r    <= o_ch_nxt;
    o_raw_r   <= o_raw_nxt;
    o_mv_r    <= o_mv_nxt;
    o_bat_r   <= o_bat_nxt;
    o_pct_r   <= o_pct_nxt;
    o_stat_r  <= o_stat_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_channel        = o_ch_r;
  assign out_avg_raw        = o_raw_r;
  assign out_avg_adc_mv     = o_mv_r;
  assign out_battery_mv     = o_bat_r;
  assign out_percent_tenths = o_pct_r;
  assign out_status         = o_stat_r;

  // ---------------- assertions ----------------
  logic counts_ok;
  always_comb begin
    counts_ok = 1'b1;
    for (int i = 0; i < bvc_pkg::CHANNELS; i++) begin
      if (count_r[i] >= bvc_pkg::CNT_W'(bvc_pkg::SAMPLES)) begin
        counts_ok = 1'b0;
      end
    end
  end

  // a closed average never leaves a count at or above the sample total
  a_counts_below_samples: assert property (@(posedge clk) disable iff (!rst_n)
    counts_ok)
    else $error("sample count reached SAMPLES without clearing");

  // percent in tenths stays within scale on every delivered result
  a_pct_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (o_pct_r <= bvc_pkg::PCT_W'(bvc_pkg::PCT_FULL)))
    else $error("percent_tenths above full scale");

  // an emitted result is never overwritten while the receiver stalls
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall && (state_r == bvc_pkg::S_EMIT)) |=>
      (state_r == bvc_pkg::S_EMIT) || !out_stall || $stable(o_bat_r))
    else $error("pending transaction overwritten under stall");

  // the divider step counter never runs past its last step
  a_div_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == bvc_pkg::S_DIV_RAW) || (state_r == bvc_pkg::S_DIV_MV) ||
     (state_r == bvc_pkg::S_DIV_PCT)) |->
      (div_cnt_r < bvc_pkg::DCNT_W'(bvc_pkg::DIV_STEPS)))
    else $error("divider step counter out of range");

endmodule

/* test/battery_voltage_classifier_test.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// battery_voltage_classifier_test
// self-checking bench for the battery voltage classifier: a scoreboard
// predicts every reading from the accepted transactions and the register
// settings, and compares it with each reading the block hands out; both
// channels idle and stall at random across several register settings
// ---------------------------------------------------------------------------
module battery_voltage_classifier_test;
  import bvc_pkg::*;

  localparam int CLK_PERIOD    = 20;
  localparam int RESET_CYCLES  = 10;
  localparam int ADC_MAX       = (1 << ADC_W) - 1;
  // room for the worst closing transaction, plus the output register
  localparam int SETTLE_CYCLES = 120;
  // cycles without any transaction on either channel before giving up
  localparam int STALL_LIMIT   = 2000;
  localparam int NUM_PHASES    = 10;
  localparam int ITEMS_PER_PHASE = 182;
  // index with no register behind it, writes must be ignored
  localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;

  // one reading as seen on the result channel
  typedef struct packed {
    logic [CH_W-1:0]   channel;
    logic [ADC_W-1:0]  avg_raw;
    logic [ADC_W-1:0]  avg_adc_mv;
    logic [REG_W-1:0]  battery_mv;
    logic [PCT_W-1:0]  percent_tenths;
    logic [STAT_W-1:0] status;
  } reading_t;

  // -------------------------------------------------------------------------
  // scoreboard: own copy of the registers and the per-channel sums, and the
  // queue of readings still owed by the block
  // -------------------------------------------------------------------------
  class charge_scoreboard;
    int slope;
    int offset_mv;
    int empty_mv;
    int full_mv;
    int low_mv;
    int over_mv;
    int disconnect_mv;
    logic [SUM_W-1:0] raw_sum [CHANNELS];
    logic [SUM_W-1:0] mv_sum [CHANNELS];
    logic [CNT_W-1:0] sample_count [CHANNELS];
    reading_t pending_readings[$];
    int errors;

    function new();
      slope         = RST_CAL_SLOPE;
      offset_mv     = $signed(RST_CAL_OFFSET);
      empty_mv      = RST_EMPTY_MV;
      full_mv       = RST_FULL_MV;
      low_mv        = RST_LOW_MV;
      over_mv       = RST_OVER_MV;
      disconnect_mv = RST_DISCONNECT_MV;
      for (int i = 0; i < CHANNELS; i++) begin
        raw_sum[i] = '0;
        mv_sum[i] = '0;
        sample_count[i] = '0;
      end
      errors = 0;
    endfunction

    function void set_register(logic [IDX_W-1:0] idx, logic [REG_W-1:0] value);
      case (idx)
        REG_CAL_SLOPE:     slope = value;
        REG_CAL_OFFSET:    offset_mv = $signed(value);
        REG_EMPTY_MV:      empty_mv = value;
        REG_FULL_MV:       full_mv = value;
        REG_LOW_MV:        low_mv = value;
        REG_OVER_MV:       over_mv = value;
        REG_DISCONNECT_MV: disconnect_mv = value;
        default: ;
      endcase
    endfunction

    // gain in 1/1024 steps, offset after the gain, round half up, clamp
    function int battery_mv_of(int pin_mv);
      longint num;
      num = longint'(pin_mv) * slope + longint'(offset_mv) * 1024;
      if (num <= 0)
        return 0;
      num = (num + 512) >>> 10;
      return (num > 65535) ? 65535 : int'(num);
    endfunction

    function int percent_of(int bat);
      longint span;
      if (full_mv <= empty_mv || bat <= empty_mv)
        return 0;
      if (bat >= full_mv)
        return PCT_FULL;
      span = full_mv - empty_mv;
      return int'((2 * PCT_FULL * longint'(bat - empty_mv) + span) / (2 * span));
    endfunction

    // thresholds are tested in this order, first hit wins
    function logic [STAT_W-1:0] status_of(int bat);
      if (bat < disconnect_mv) return ST_NOT_CONNECTED;
      if (bat <= empty_mv)     return ST_EMPTY;
      if (bat < low_mv)        return ST_LOW;
      if (bat > over_mv)       return ST_OVER_VOLTAGE;
      if (bat >= full_mv)      return ST_FULL;
      return ST_NORMAL;
    endfunction

    function reading_t make_reading(int ch, int raw, int mv);
      reading_t r;
      int bat;
      bat = battery_mv_of(mv);
      r.channel        = CH_W'(ch);
      r.avg_raw        = ADC_W'(raw);
      r.avg_adc_mv     = ADC_W'(mv);
      r.battery_mv     = REG_W'(bat);
      r.percent_tenths = PCT_W'(percent_of(bat));
      r.status         = status_of(bat);
      return r;
    endfunction

    function void note_input(logic op, logic [CH_W-1:0] ch,
                             logic [ADC_W-1:0] raw, logic [ADC_W-1:0] mv);
      if (ch >= CHANNELS)
        return;
      if (op == OP_AVERAGED) begin
        pending_readings.push_back(make_reading(ch, raw, mv));
        return;
      end
      raw_sum[ch] += raw;
      mv_sum[ch] += mv;
      sample_count[ch] += 1'b1;
      if (sample_count[ch] < SAMPLES)
        return;
      pending_readings.push_back(make_reading(ch, int'(raw_sum[ch] / SAMPLES),
                                              int'(mv_sum[ch] / SAMPLES)));
      raw_sum[ch] = '0;
      mv_sum[ch] = '0;
      sample_count[ch] = '0;
    endfunction

    function string describe(reading_t r);
      return $sformatf("ch %0d raw %0d mv %0d bat %0d pct %0d status %0d",
                       r.channel, r.avg_raw, r.avg_adc_mv, r.battery_mv,
                       r.percent_tenths, r.status);
    endfunction

    function void check_reading(reading_t got);
      reading_t want;
      if (pending_readings.size() == 0) begin
        errors++;
        $display("%0t: unexpected reading, expected none, actual %s", $time,
                 describe(got));
        return;
      end
      want = pending_readings.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: reading differs, expected %s, actual %s", $time,
                 describe(want), describe(got));
      end
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // clock, block inputs and the scoreboard
  // -------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_op = OP_ACCUMULATE;
  logic [CH_W-1:0]   in_channel = '0;
  logic [ADC_W-1:0]  in_sample_raw = '0;
  logic [ADC_W-1:0]  in_sample_mv = '0;

  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [CH_W-1:0]   out_channel;
  logic [ADC_W-1:0]  out_avg_raw;
  logic [ADC_W-1:0]  out_avg_adc_mv;
  logic [REG_W-1:0]  out_battery_mv;
  logic [PCT_W-1:0]  out_percent_tenths;
  logic [STAT_W-1:0] out_status;

  logic              cfg_we = 1'b0;
  logic [IDX_W-1:0]  cfg_index = '0;
  logic [REG_W-1:0]  cfg_wdata = '0;

  // when set, that side runs back to back without idle cycles
  bit in_steady = 1'b0;
  bit out_steady = 1'b0;
  int idle_cycles = 0;

  charge_scoreboard board = new();

  always #(CLK_PERIOD / 2) clk = ~clk;

  battery_voltage_classifier dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_op              (in_op),
    .in_channel         (in_channel),
    .in_sample_raw      (in_sample_raw),
    .in_sample_mv       (in_sample_mv),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_channel        (out_channel),
    .out_avg_raw        (out_avg_raw),
    .out_avg_adc_mv     (out_avg_adc_mv),
    .out_battery_mv     (out_battery_mv),
    .out_percent_tenths (out_percent_tenths),
    .out_status         (out_status),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  // -------------------------------------------------------------------------
  // stimulus helpers
  // -------------------------------------------------------------------------

  // adc level with extra weight on both ends of the scale
  function automatic logic [ADC_W-1:0] random_level();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return ADC_W'(ADC_MAX);
      default: return ADC_W'($urandom_range(0, ADC_MAX));
    endcase
  endfunction

  // sample jittering around a channel's level, clamped to the adc range
  function automatic logic [ADC_W-1:0] near_level(logic [ADC_W-1:0] level);
    int v;
    v = int'(level) + int'($urandom_range(0, 128)) - 64;
    if (v < 0)
      v = 0;
    if (v > ADC_MAX)
      v = ADC_MAX;
    return ADC_W'(v);
  endfunction

  // one input transaction; valid only drops when an idle gap is drawn, so a
  // back to back transaction never sees valid lowered and raised in one step
  task automatic send_item(input logic op, input logic [CH_W-1:0] ch,
                           input logic [ADC_W-1:0] raw,
                           input logic [ADC_W-1:0] mv);
    int gap;
    gap = in_steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_op         <= op;
    in_channel    <= ch;
    in_sample_raw <= raw;
    in_sample_mv  <= mv;
    do @(posedge clk); while (in_stall);
    board.note_input(op, ch, raw, mv);
  endtask

  // hold the input side until every owed reading has come out
  task automatic wait_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.pending_readings.size() != 0);
  endtask

  // write all seven registers, one per clock, then release the write enable
  task automatic write_settings(input logic [REG_W-1:0] slope,
                                input logic [REG_W-1:0] offset,
                                input logic [REG_W-1:0] empty,
                                input logic [REG_W-1:0] full,
                                input logic [REG_W-1:0] low,
                                input logic [REG_W-1:0] over,
                                input logic [REG_W-1:0] disconnect);
    logic [REG_W-1:0] regs [8];
    regs[REG_CAL_SLOPE]     = slope;
    regs[REG_CAL_OFFSET]    = offset;
    regs[REG_EMPTY_MV]      = empty;
    regs[REG_FULL_MV]       = full;
    regs[REG_LOW_MV]        = low;
    regs[REG_OVER_MV]       = over;
    regs[REG_DISCONNECT_MV] = disconnect;
    for (int i = 0; i < REG_UNUSED; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= IDX_W'(i);
      cfg_wdata <= regs[i];
      @(posedge clk);
      board.set_register(IDX_W'(i), regs[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // -------------------------------------------------------------------------
  // result side: draw a stall per reading, then take the next valid reading
  // -------------------------------------------------------------------------
  initial begin
    reading_t got;
    int hold;
    forever begin
      if ($urandom_range(0, 31) == 0)
        out_steady = ~out_steady;
      hold = out_steady ? 0 : $urandom_range(0, 4);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(rst_n && out_valid));
      got = '{out_channel, out_avg_raw, out_avg_adc_mv, out_battery_mv,
              out_percent_tenths, out_status};
      board.check_reading(got);
    end
  end

  // watchdog: any transaction on either channel restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("battery_voltage_classifier: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // -------------------------------------------------------------------------
  // main sequence: reset, then phases of register settings with a directed
  // opening and a random body each
  // -------------------------------------------------------------------------
  initial begin
    logic             op;
    logic [CH_W-1:0]  ch;
    logic [ADC_W-1:0] raw;
    logic [ADC_W-1:0] mv;
    logic [ADC_W-1:0] raw_level [CHANNELS];
    logic [ADC_W-1:0] mv_level [CHANNELS];
    logic [REG_W-1:0] junk;
    int slope_r, offset_r, top, disc_r, empty_r, low_r, full_r, over_r;

    for (int c = 0; c < CHANNELS; c++) begin
      raw_level[c] = random_level();
      mv_level[c] = random_level();
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // a write to the index with no register behind it must change nothing
    junk = REG_W'($urandom);
    cfg_we    <= 1'b1;
    cfg_index <= REG_UNUSED;
    cfg_wdata <= junk;
    @(posedge clk);
    board.set_register(REG_UNUSED, junk);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase > 0) begin
        // registers only change with the block idle: nothing owed, and time
        // for a closing transaction still in flight to finish
        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
      end
      case (phase)
        0: begin
          // reset values written back explicitly
          write_settings(RST_CAL_SLOPE, RST_CAL_OFFSET, RST_EMPTY_MV, RST_FULL_MV,
                         RST_LOW_MV, RST_OVER_MV, RST_DISCONNECT_MV);
        end
        1: begin
          // top gain and offset: battery voltage saturates, full open range
          write_settings(16'hFFFF, 16'h7FFF, 16'h0000, 16'hFFFF,
                         16'h0000, 16'hFFFE, 16'h0000);
        end
        2: begin
          // zero gain, most negative offset: voltage floors at zero, and an
          // empty range with full equal to empty
          write_settings(16'h0000, 16'h8000, 16'h0000, 16'h0000,
                         16'h0000, 16'h0000, 16'h0000);
        end
        3: begin
          // full below empty, percent stays zero
          write_settings(16'd4096, 16'h0000, 16'd12000, 16'd8000,
                         16'd10000, 16'hFFFF, 16'd500);
        end
        default: begin
          // thresholds spread over the reachable battery range so every
          // status and a spread of percentages show up
          slope_r  = $urandom_range(512, 8192);
          offset_r = int'($urandom_range(0, 4000)) - 2000;
          top      = (ADC_MAX * slope_r) / 1024 + offset_r;
          disc_r   = $urandom_range(0, top / 8);
          empty_r  = $urandom_range(disc_r, top / 3);
          low_r    = $urandom_range(empty_r, top / 2);
          full_r   = $urandom_range(low_r, (3 * top) / 4);
          over_r   = $urandom_range(full_r, top);
          write_settings(REG_W'(slope_r), REG_W'(offset_r), REG_W'(empty_r),
                         REG_W'(full_r), REG_W'(low_r), REG_W'(over_r),
                         REG_W'(disc_r));
        end
      endcase

      if (phase == 0) begin
        // averaged pairs at the scale ends and mixed
        send_item(OP_AVERAGED, 2'd0, '0, '0);
        send_item(OP_AVERAGED, 2'd1, ADC_W'(ADC_MAX), ADC_W'(ADC_MAX));
        send_item(OP_AVERAGED, 2'd2, '0, ADC_W'(ADC_MAX));
        send_item(OP_AVERAGED, 2'd3, ADC_W'(ADC_MAX), '0);
        // one below and right at the disconnect threshold
        send_item(OP_AVERAGED, 2'd0, 12'd999, 12'd999);
        send_item(OP_AVERAGED, 2'd1, 12'd1000, 12'd1000);
        // an accumulation left open on channel 0, no reading yet
        send_item(OP_ACCUMULATE, 2'd0, ADC_W'(ADC_MAX), 12'd1);
        send_item(OP_ACCUMULATE, 2'd0, '0, 12'd7);
        // a complete average of top codes on channel 3
        for (int k = 0; k < SAMPLES; k++)
          send_item(OP_ACCUMULATE, 2'd3, ADC_W'(ADC_MAX), ADC_W'(ADC_MAX));
      end

      // random body: mostly steady per-channel sample streams that close
      // averages, with averaged pairs mixed in
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(0, 31) == 0)
          in_steady = ~in_steady;
        if ($urandom_range(0, 99) == 0)
          wait_until_drained();
        ch = $urandom_range(0, CHANNELS - 1);
        if ($urandom_range(0, 15) == 0) begin
          raw_level[ch] = random_level();
          mv_level[ch] = random_level();
        end
        op = ($urandom_range(0, 9) < 3) ? OP_AVERAGED : OP_ACCUMULATE;
        if (op == OP_AVERAGED) begin
          raw = random_level();
          mv = random_level();
        end else begin
          raw = near_level(raw_level[ch]);
          mv = near_level(mv_level[ch]);
        end
        send_item(op, ch, raw, mv);
      end
    end

    // drain, then leave room for any late or extra reading
    wait_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.pending_readings.size() == 0) begin
      $display("battery_voltage_classifier: match");
    end else begin
      $display("battery_voltage_classifier: mismatch");
    end
    $finish;
  end

endmodule
